### src/plscan_pkg.sv
package plscan_pkg;

   // field widths
   localparam int ByteW = 8;
   localparam int LenW  = 5;
   localparam int CntW  = 4;
   localparam int CfgW  = 4;

   // register reset values
   localparam logic [CfgW-1:0] REQ_LEN_RESET = 4'd14;
   localparam logic [CfgW-1:0] BUDGET_RESET  = 4'd12;

   // register indexes
   typedef enum logic {
      CSR_REQUIRED_LENGTH    = 1'b0,
      CSR_INSTRUCTION_BUDGET = 1'b1
   } csr_index_type;

   // instruction bytes
   localparam logic [ByteW-1:0] BYTE_ENDBR_0 = 8'hF3;
   localparam logic [ByteW-1:0] BYTE_ESCAPE  = 8'h0F;
   localparam logic [ByteW-1:0] BYTE_ENDBR_2 = 8'h1E;
   localparam logic [ByteW-1:0] BYTE_ENDBR_3 = 8'hFA;
   localparam logic [ByteW-1:0] BYTE_NOP     = 8'h90;
   localparam logic [ByteW-1:0] BYTE_REX_B   = 8'h41;
   localparam logic [ByteW-1:0] BYTE_OPSIZE  = 8'h66;
   localparam logic [ByteW-1:0] REXW_MASK    = 8'hF8;
   localparam logic [ByteW-1:0] REXW_BASE    = 8'h48;
   localparam logic [3:0]       PUSHPOP_ROW  = 4'h5;

   // opcodes allowed after rex.w
   localparam logic [ByteW-1:0] OP_GRP1_IMM8  = 8'h83;
   localparam logic [ByteW-1:0] OP_GRP1_IMM32 = 8'h81;
   localparam logic [ByteW-1:0] OP_MOV_IMM32  = 8'hC7;
   localparam logic [ByteW-1:0] OP_MOV_STORE  = 8'h89;
   localparam logic [ByteW-1:0] OP_MOV_LOAD   = 8'h8B;
   localparam logic [ByteW-1:0] OP_LEA        = 8'h8D;
   localparam logic [ByteW-1:0] OP_TEST       = 8'h85;
   localparam logic [ByteW-1:0] OP_CMP        = 8'h3B;

   // modrm codes
   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP32   = 2'd2;
   localparam logic [1:0] MOD_REGISTER = 2'd3;
   localparam logic [2:0] RM_SIB       = 3'd4;
   localparam logic [2:0] RM_RIP       = 3'd5;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_DONE,
      PH_OPCODE,
      PH_ENDBR_1,
      PH_ENDBR_2,
      PH_ENDBR_3,
      PH_REXB,
      PH_P66_ESC,
      PH_P66_OP,
      PH_P66_MODRM,
      PH_REXW_OP,
      PH_REXW_MODRM,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic [LenW-1:0]   total;
      logic [CntW-1:0]   count;
      logic [3:0]        skip;
      logic [ByteW-1:0]  held;
      logic [3:0]        cur;
   } scan_state_type;

   typedef struct packed {
      logic            valid;
      logic [LenW-1:0] length;
      logic            accepted;
   } scan_result_type;

   // opcode accepted after a rex.w prefix
   function automatic logic rexw_opcode_ok(input logic [ByteW-1:0] b);
      logic ok;
      case (b)
         OP_GRP1_IMM8, OP_GRP1_IMM32, OP_MOV_IMM32, OP_MOV_STORE,
         OP_MOV_LOAD, OP_LEA, OP_TEST, OP_CMP: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   // immediate bytes carried by a rex.w opcode
   function automatic logic [2:0] rexw_imm_len(input logic [ByteW-1:0] op);
      logic [2:0] n;
      case (op)
         OP_GRP1_IMM8:                n = 3'd1;
         OP_GRP1_IMM32, OP_MOV_IMM32: n = 3'd4;
         default:                     n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

### src/prologue_length_scanner.sv
// result: registered, on rsp in the cycle after the code byte that ends the scan is accepted
// throughput: one code byte per cycle, unless req is stalled by a held result;
// a held result does not stall req while rsp_tready is high
// reset: synchronous, active high; scan idle until a start byte,
// required_length back to 14 and instruction_budget back to 12
module prologue_length_scanner (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [plscan_pkg::ByteW-1:0] req_tdata,  // [7:0] code_byte
   input  logic                         req_tuser,  // [0] start_req
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,  // [4:0] covered_length, [7:5] zero
   output logic                         rsp_tuser,  // [0] accepted
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [plscan_pkg::CfgW-1:0]  csr_data
);
   import plscan_pkg::*;

   scan_state_type  state_ff, state_in, state_next;
   scan_result_type result;
   logic [CfgW-1:0] req_len_ff, req_len_in;
   logic [CfgW-1:0] budget_ff, budget_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [LenW-1:0] rsp_len_ff, rsp_len_in;
   logic            rsp_ok_ff, rsp_ok_in;
   logic            req_take;
   logic            rsp_load;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_load   = req_take && result.valid;
   assign csr_ready  = 1'b1;

   plscan_decode u_decode (
      .state_q            (state_ff),
      .code_byte          (req_tdata),
      .start_req          (req_tuser),
      .required_length    (req_len_ff),
      .instruction_budget (budget_ff),
      .state_d            (state_next),
      .result             (result)
   );

   // configuration writes
   always_comb begin
      req_len_in = req_len_ff;
      budget_in  = budget_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_REQUIRED_LENGTH:    req_len_in = csr_data;
            CSR_INSTRUCTION_BUDGET: budget_in  = csr_data;
            default:                req_len_in = req_len_ff;
         endcase
      end
   end

   // scan state advances on each accepted item
   assign state_in = req_take ? state_next : state_ff;

   // output register
   always_comb begin
      rsp_len_in   = rsp_len_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = result.length;
         rsp_ok_in    = result.accepted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= PH_IDLE;
         state_ff.total <= '0;
         state_ff.count <= '0;
         state_ff.skip  <= '0;
         state_ff.held  <= '0;
         state_ff.cur   <= '0;
         req_len_ff     <= REQ_LEN_RESET;
         budget_ff      <= BUDGET_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_len_ff   <= req_len_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff <= rsp_len_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - LenW){1'b0}}, rsp_len_ff};
   assign rsp_tuser  = rsp_ok_ff;

   // a refusal never carries a length, a success always does
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_len_ff == '0)
      else $error("refusal with nonzero length");

   a_accept_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> rsp_len_ff != '0)
      else $error("success with zero length");

   // after any result the scan waits for the next start
   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> state_ff.phase == PH_DONE)
      else $error("scan still running after a result");

   // bytes outside a scan give no result
   a_quiet_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_tuser && (state_ff.phase == PH_IDLE || state_ff.phase == PH_DONE)
      |-> !result.valid)
      else $error("result outside a scan");

   // an empty output register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty output register");

endmodule

### src/plscan_decode.sv
module plscan_decode (
   input  plscan_pkg::scan_state_type     state_q,
   input  logic [plscan_pkg::ByteW-1:0]   code_byte,
   input  logic                           start_req,
   input  logic [plscan_pkg::CfgW-1:0]    required_length,
   input  logic [plscan_pkg::CfgW-1:0]    instruction_budget,
   output plscan_pkg::scan_state_type     state_d,
   output plscan_pkg::scan_result_type    result
);
   import plscan_pkg::*;

   scan_state_type  base;
   logic            start_fail;
   logic [1:0]      mod_bits;
   logic [2:0]      rm_bits;
   logic            rip_rel;
   logic [2:0]      extra_len;
   logic [3:0]      rexw_extra;
   logic [3:0]      skip_dec;
   logic            step_refuse;
   logic            step_finish;
   phase_type       step_phase;
   logic [3:0]      step_cur;
   logic [3:0]      step_skip;
   logic [ByteW-1:0] step_held;
   logic [LenW-1:0] sum_len;
   logic [CntW-1:0] count_inc;
   logic            hit;
   logic            exhaust;

   // a start clears the scan and decodes this byte as an opcode
   always_comb begin
      base = state_q;
      if (start_req) begin
         base.phase = PH_OPCODE;
         base.total = '0;
         base.count = '0;
         base.skip  = '0;
         base.held  = '0;
         base.cur   = '0;
      end
   end

   assign start_fail = start_req &&
      (required_length == '0 || instruction_budget == '0);

   // modrm: sib and displacement bytes
   assign mod_bits = code_byte[7:6];
   assign rm_bits  = code_byte[2:0];
   assign rip_rel  = (mod_bits == MOD_INDIRECT) && (rm_bits == RM_RIP);

   always_comb begin
      extra_len = 3'd0;
      if (rm_bits == RM_SIB && mod_bits != MOD_REGISTER) begin
         extra_len = 3'd1;
      end
      if (mod_bits == MOD_DISP8) begin
         extra_len = extra_len + 3'd1;
      end else if (mod_bits == MOD_DISP32) begin
         extra_len = extra_len + 3'd4;
      end
   end

   assign rexw_extra = {1'b0, extra_len} + {1'b0, rexw_imm_len(base.held)};
   assign skip_dec   = (base.skip != 4'd0) ? base.skip - 4'd1 : 4'd0;

   // per-phase byte decode
   always_comb begin
      step_refuse = 1'b0;
      step_finish = 1'b0;
      step_phase  = base.phase;
      step_cur    = base.cur;
      step_skip   = base.skip;
      step_held   = base.held;
      unique case (base.phase)
         PH_OPCODE: begin
            if (code_byte == BYTE_ENDBR_0) begin
               step_phase = PH_ENDBR_1;
            end else if (code_byte == BYTE_NOP || code_byte[7:4] == PUSHPOP_ROW) begin
               step_cur    = 4'd1;
               step_finish = 1'b1;
            end else if (code_byte == BYTE_REX_B) begin
               step_phase = PH_REXB;
            end else if (code_byte == BYTE_OPSIZE) begin
               step_phase = PH_P66_ESC;
            end else if ((code_byte & REXW_MASK) == REXW_BASE) begin
               step_phase = PH_REXW_OP;
            end else begin
               step_refuse = 1'b1;
            end
         end
         PH_ENDBR_1: begin
            if (code_byte == BYTE_ESCAPE) step_phase = PH_ENDBR_2;
            else step_refuse = 1'b1;
         end
         PH_ENDBR_2: begin
            if (code_byte == BYTE_ENDBR_2) step_phase = PH_ENDBR_3;
            else step_refuse = 1'b1;
         end
         PH_ENDBR_3: begin
            if (code_byte == BYTE_ENDBR_3) begin
               step_cur    = 4'd4;
               step_finish = 1'b1;
            end else begin
               step_refuse = 1'b1;
            end
         end
         PH_REXB: begin
            if (code_byte[7:4] == PUSHPOP_ROW) begin
               step_cur    = 4'd2;
               step_finish = 1'b1;
            end else begin
               step_refuse = 1'b1;
            end
         end
         PH_P66_ESC: begin
            if (code_byte == BYTE_ESCAPE) step_phase = PH_P66_OP;
            else step_refuse = 1'b1;
         end
         PH_P66_OP: begin
            step_held  = code_byte;
            step_phase = PH_P66_MODRM;
         end
         PH_P66_MODRM: begin
            step_cur  = 4'd4 + {1'b0, extra_len};
            step_skip = {1'b0, extra_len};
            if (rip_rel) step_refuse = 1'b1;
            else if (extra_len == 3'd0) step_finish = 1'b1;
            else step_phase = PH_SKIP;
         end
         PH_REXW_OP: begin
            if (rexw_opcode_ok(code_byte)) begin
               step_held  = code_byte;
               step_phase = PH_REXW_MODRM;
            end else begin
               step_refuse = 1'b1;
            end
         end
         PH_REXW_MODRM: begin
            step_cur  = 4'd3 + rexw_extra;
            step_skip = rexw_extra;
            if (rip_rel) step_refuse = 1'b1;
            else if (rexw_extra == 4'd0) step_finish = 1'b1;
            else step_phase = PH_SKIP;
         end
         PH_SKIP: begin
            step_skip = skip_dec;
            if (skip_dec == 4'd0) step_finish = 1'b1;
         end
         PH_IDLE, PH_DONE: begin
            step_phase = base.phase;
         end
         default: begin
            step_phase = base.phase;
         end
      endcase
   end

   // instruction end: running total and budget
   assign sum_len   = base.total + {1'b0, step_cur};
   assign count_inc = base.count + 4'd1;
   assign hit       = sum_len >= {1'b0, required_length};
   assign exhaust   = count_inc >= instruction_budget;

   // next state
   always_comb begin
      state_d       = base;
      state_d.phase = step_phase;
      state_d.cur   = step_cur;
      state_d.skip  = step_skip;
      state_d.held  = step_held;
      if (start_fail) begin
         state_d       = base;
         state_d.phase = PH_DONE;
      end else if (step_refuse) begin
         state_d.phase = PH_DONE;
      end else if (step_finish) begin
         state_d.total = sum_len;
         state_d.count = count_inc;
         state_d.phase = (hit || exhaust) ? PH_DONE : PH_OPCODE;
      end
   end

   // result
   always_comb begin
      result.valid    = start_fail || step_refuse || (step_finish && (hit || exhaust));
      result.accepted = !start_fail && !step_refuse && step_finish && hit;
      result.length   = result.accepted ? sum_len : '0;
   end

endmodule
